// ----- sv/dlwc_pkg.sv -----
package dlwc_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int NCOL_W  = COL_W + 1;
  localparam int ROW_W   = 16;
  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int WIN_W   = $clog2(2 * MAX_RADIUS + 1);
  localparam int SLOT_W  = $clog2(RING_ROWS);
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int DEPTH   = RING_ROWS * MAX_COLS;
  localparam int CNT_W   = $clog2(RING_ROWS * RING_ROWS + 1);
  localparam int H_W     = 18;
  localparam int S_W     = 14;
  localparam int SSUM_W  = S_W + CNT_W;
  localparam int ENTRY_W = H_W + 1 + S_W + 1;
  localparam int CLS_W   = 3;
  localparam int REL_W   = 17;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 18;

  localparam logic [CFG_A_W-1:0] REG_NUM_COLS   = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_NUM_ROWS   = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_RADIUS     = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_FLAT_LIM   = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_REL_LOW    = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_REL_HIGH   = 3'd5;
  localparam logic [CFG_A_W-1:0] REG_ALT_LOW    = 3'd6;
  localparam logic [CFG_A_W-1:0] REG_ALT_HIGH   = 3'd7;

  localparam logic [CLS_W-1:0] CLS_NONE  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_FLAT  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_LOW   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_HILL  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_MID   = 3'd4;
  localparam logic [CLS_W-1:0] CLS_HIGH  = 3'd5;

  typedef struct packed {
    logic [S_W-1:0]        flat_lim;
    logic [REL_W-1:0]      rel_low;
    logic [REL_W-1:0]      rel_high;
    logic signed [H_W-1:0] alt_low;
    logic signed [H_W-1:0] alt_high;
  } limits_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [SLOT_W-1:0]  wr_slot;
    logic [COL_W-1:0]   wr_col;
    logic               emit;
    logic               last;
    logic [ROW_W-1:0]   cr;
    logic [COL_W-1:0]   cc;
    logic [SLOT_W-1:0]  top_slot;
    logic [COL_W-1:0]   base_col;
    logic [RAD_W-1:0]   rad;
  } job_t;

endpackage

// ----- sv/dlwc_front.sv -----
module dlwc_front import dlwc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_A_W-1:0]     cfg_addr,
  input  logic [CFG_D_W-1:0]     cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [H_W-1:0]  in_height,
  input  logic                   in_height_valid,
  input  logic [S_W-1:0]         in_slope,
  input  logic                   in_slope_valid,
  output logic                   push,
  output job_t                   job,
  input  logic                   q_full,
  output limits_t                lim
);

  logic [NCOL_W-1:0] num_cols_r;
  logic [ROW_W-1:0]  num_rows_r;
  logic [RAD_W-1:0]  radius_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [SLOT_W-1:0] slot_r;
  limits_t           lim_r;

  logic [NCOL_W-1:0] cols;
  logic [ROW_W-1:0]  rows;
  logic [RAD_W-1:0]  rad;
  logic [WIN_W-1:0]  wsz;
  logic              row_end, frame_end;
  logic [SLOT_W:0]   top_tmp;

  always_comb begin
    if (num_cols_r == '0) cols = NCOL_W'(1);
    else if (num_cols_r > NCOL_W'(MAX_COLS)) cols = NCOL_W'(MAX_COLS);
    else cols = num_cols_r;
    rows = (num_rows_r == '0) ? ROW_W'(1) : num_rows_r;
    if (radius_r == '0) rad = RAD_W'(1);
    else if (radius_r > RAD_W'(MAX_RADIUS)) rad = RAD_W'(MAX_RADIUS);
    else rad = radius_r;
    wsz = WIN_W'({rad, 1'b0});
    row_end   = ({1'b0, col_r} + NCOL_W'(1)) >= cols;
    frame_end = ({1'b0, row_r} + 17'd1) >= {1'b0, rows};
    top_tmp = {1'b0, slot_r} + (SLOT_W+1)'(RING_ROWS) - (SLOT_W+1)'(wsz);
    if (top_tmp >= (SLOT_W+1)'(RING_ROWS)) top_tmp = top_tmp - (SLOT_W+1)'(RING_ROWS);
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign lim      = lim_r;

  always_comb begin
    job.entry    = {in_height_valid, in_height, in_slope_valid, in_slope};
    job.wr_slot  = slot_r;
    job.wr_col   = col_r;
    job.emit     = (row_r >= ROW_W'(wsz)) && (col_r >= COL_W'(wsz));
    job.last     = (row_r == rows - ROW_W'(1)) && ({1'b0, col_r} == cols - NCOL_W'(1));
    job.cr       = row_r - ROW_W'(rad);
    job.cc       = col_r - COL_W'(rad);
    job.top_slot = top_tmp[SLOT_W-1:0];
    job.base_col = col_r - COL_W'(wsz);
    job.rad      = rad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r     <= NCOL_W'(1024);
      num_rows_r     <= ROW_W'(1024);
      radius_r       <= RAD_W'(5);
      lim_r.flat_lim <= S_W'(300);
      lim_r.rel_low  <= REL_W'(1000);
      lim_r.rel_high <= REL_W'(2000);
      lim_r.alt_low  <= H_W'(4000);
      lim_r.alt_high <= H_W'(8000);
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_NUM_COLS: num_cols_r     <= cfg_data[NCOL_W-1:0];
        REG_NUM_ROWS: num_rows_r     <= cfg_data[ROW_W-1:0];
        REG_RADIUS:   radius_r       <= cfg_data[RAD_W-1:0];
        REG_FLAT_LIM: lim_r.flat_lim <= cfg_data[S_W-1:0];
        REG_REL_LOW:  lim_r.rel_low  <= cfg_data[REL_W-1:0];
        REG_REL_HIGH: lim_r.rel_high <= cfg_data[REL_W-1:0];
        REG_ALT_LOW:  lim_r.alt_low  <= cfg_data[H_W-1:0];
        REG_ALT_HIGH: lim_r.alt_high <= cfg_data[H_W-1:0];
        default: ;
      endcase
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (push) begin
      if (row_end) begin
        col_r <= '0;
        if (frame_end) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_r + ROW_W'(1);
          slot_r <= (slot_r == SLOT_W'(RING_ROWS - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

endmodule

// ----- sv/dlwc_queue.sv -----
module dlwc_queue import dlwc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_job = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/dlwc_back.sv -----
module dlwc_back import dlwc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  job_t             q_job,
  output logic             pop,
  input  limits_t          lim,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ROW_W-1:0] out_center_row,
  output logic [COL_W-1:0] out_center_col,
  output logic [CLS_W-1:0] out_landform_class,
  output logic             out_last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EVAL  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  job_t   job_r;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_v_r, rd_ctr_r;

  logic [WIN_W-1:0]  ri_r, ci_r;
  logic [SLOT_W-1:0] rslot_r;
  logic [SSUM_W-1:0] ssum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic signed [H_W-1:0] hmin_r, hmax_r, ctr_h_r;
  logic              any_r, ctr_v_r;

  logic              out_valid_r, out_last_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic [CLS_W-1:0]  out_cls_r;

  logic [WIN_W-1:0]  wsz;
  logic [ADDR_W-1:0] rd_addr;
  logic              issue, out_free;
  logic signed [H_W-1:0] e_h;
  logic              e_hv, e_sv;
  logic [S_W-1:0]    e_s;
  logic [SSUM_W-1:0] lim_prod;
  logic [H_W:0]      relief;
  logic [CLS_W-1:0]  cls;

  assign wsz      = WIN_W'({job_r.rad, 1'b0});
  assign issue    = state_r == S_SCAN;
  assign rd_addr  = {rslot_r, COL_W'(job_r.base_col + COL_W'(ci_r))};
  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) mem[{job_r.wr_slot, job_r.wr_col}] <= job_r.entry;
    if (issue) rd_data_r <= mem[rd_addr];
  end

  assign {e_hv, e_h, e_sv, e_s} = rd_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_WRITE;
      S_WRITE: state_nxt = job_r.emit ? S_SCAN : S_IDLE;
      S_SCAN:  if (ci_r == wsz && ri_r == wsz) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_EVAL;
      S_EVAL:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Class decision on the finished window sums.
  always_comb begin
    lim_prod = SSUM_W'(lim.flat_lim) * SSUM_W'(cnt_r);
    relief   = (H_W+1)'(signed'({hmax_r[H_W-1], hmax_r}) - signed'({hmin_r[H_W-1], hmin_r}));
    cls = CLS_NONE;
    if (!ctr_v_r) cls = CLS_NONE;
    else if (ssum_r <= lim_prod) cls = CLS_FLAT;
    else if (relief <= (H_W+1)'(lim.rel_low)) cls = CLS_LOW;
    else if (relief <= (H_W+1)'(lim.rel_high) && ctr_h_r <= lim.alt_low) cls = CLS_HILL;
    else if (relief > (H_W+1)'(lim.rel_high)) begin
      if (ctr_h_r > lim.alt_low && ctr_h_r <= lim.alt_high) cls = CLS_MID;
      else if (ctr_h_r > lim.alt_high) cls = CLS_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= q_job;
    if (state_r == S_WRITE) begin
      ri_r    <= '0;
      ci_r    <= '0;
      rslot_r <= job_r.top_slot;
      ssum_r  <= '0;
      cnt_r   <= '0;
      any_r   <= 1'b0;
    end else if (issue) begin
      if (ci_r == wsz) begin
        ci_r    <= '0;
        ri_r    <= ri_r + WIN_W'(1);
        rslot_r <= (rslot_r == SLOT_W'(RING_ROWS - 1)) ? '0 : rslot_r + SLOT_W'(1);
      end else begin
        ci_r <= ci_r + WIN_W'(1);
      end
    end
    rd_ctr_r <= issue && (ri_r == WIN_W'(job_r.rad)) && (ci_r == WIN_W'(job_r.rad));
    if (rd_v_r) begin
      if (e_sv) begin
        ssum_r <= ssum_r + SSUM_W'(e_s);
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      if (e_hv) begin
        any_r  <= 1'b1;
        hmin_r <= (!any_r || e_h < hmin_r) ? e_h : hmin_r;
        hmax_r <= (!any_r || e_h > hmax_r) ? e_h : hmax_r;
      end
      if (rd_ctr_r) begin
        ctr_v_r <= e_hv;
        ctr_h_r <= e_h;
      end
    end
    if (state_r == S_EVAL && out_free) begin
      out_row_r  <= job_r.cr;
      out_col_r  <= job_r.cc;
      out_cls_r  <= cls;
      out_last_r <= job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (state_r == S_EVAL && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_center_row     = out_row_r;
  assign out_center_col     = out_col_r;
  assign out_landform_class = out_cls_r;
  assign out_last           = out_last_r;

endmodule

// ----- sv/dem_landform_window_classifier_top.sv -----
// In the back end a border cell is only written into the line store; an interior
// cell then passes through the window scan, drain and evaluate states to its
// request on the output. The scan makes one window read a cycle from the
// single-port line store, and the back end takes no new cell until it is done.
// Reset (rst_n low, synchronous) clears positions, queue, control and loads the
// register defaults; line store contents stay undefined until written.

// The front end keeps the raster position and the configuration registers and
// turns each input request into a job. A two-entry queue decouples it from the
// back end, which writes the cell into the line store and, for an interior cell,
// sweeps the window one entry per cycle and classifies it into a registered output.
module dem_landform_window_classifier_top import dlwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_D_W-1:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [H_W-1:0] in_height,
  input  logic                  in_height_valid,
  input  logic [S_W-1:0]        in_slope,
  input  logic                  in_slope_valid,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROW_W-1:0]      out_center_row,
  output logic [COL_W-1:0]      out_center_col,
  output logic [CLS_W-1:0]      out_landform_class,
  output logic                  out_last
);

  job_t    push_job, pop_job;
  limits_t lim;
  logic    push, pop, q_full, q_empty;

  // Registers are to be written only while the block is idle; the block does not enforce it. The port never stalls.
  assign cfg_ready = 1'b1;

  dlwc_front u_front (
    .clk, .rst_n,
    .cfg_valid, .cfg_addr, .cfg_data,
    .in_valid, .in_ready, .in_height, .in_height_valid, .in_slope, .in_slope_valid,
    .push, .job(push_job), .q_full, .lim
  );

  dlwc_queue u_queue (
    .clk, .rst_n,
    .push, .push_job, .full(q_full),
    .pop, .pop_job, .empty(q_empty)
  );

  // The back end owns the line store, so a queued cell never overwrites a row
  // that an earlier window still needs.
  dlwc_back u_back (
    .clk, .rst_n,
    .q_empty, .q_job(pop_job), .pop, .lim,
    .out_valid, .out_ready, .out_center_row, .out_center_col,
    .out_landform_class, .out_last
  );

endmodule

// ----- sv/dlwc_checker.sv -----
module dlwc_checker import dlwc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] out_center_row,
  input logic [COL_W-1:0] out_center_col,
  input logic [CLS_W-1:0] out_landform_class,
  input logic             out_last
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_center_row)
      && $stable(out_center_col) && $stable(out_landform_class) && $stable(out_last))
    else $error("stalled result changed");

  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_landform_class <= CLS_HIGH)
    else $error("class code out of range");

endmodule

bind dem_landform_window_classifier_top dlwc_checker u_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
  import dlwc_pkg::*;

  // One classified centre cell as it leaves the block.
  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CLS_W-1:0] cls;
    logic             last;
  } landform_t;

  // Scoreboard: keeps its own copy of the line stores, the raster position
  // and the registers; classifies and queues each window an accepted cell closes.
  class landform_scoreboard;
    logic [H_W:0]          height_ring [RING_ROWS][MAX_COLS];
    logic [S_W:0]          slope_ring  [RING_ROWS][MAX_COLS];
    int unsigned           row_pos;
    int unsigned           col_pos;
    logic [NCOL_W-1:0]     cols_reg;
    logic [ROW_W-1:0]      rows_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [S_W-1:0]        flat_reg;
    logic [REL_W-1:0]      rel_low_reg;
    logic [REL_W-1:0]      rel_high_reg;
    logic signed [H_W-1:0] alt_low_reg;
    logic signed [H_W-1:0] alt_high_reg;
    landform_t             expected_q[$];
    int                    errors;

    function new();
      row_pos = 0;
      col_pos = 0;
      cols_reg = 1024;
      rows_reg = 1024;
      rad_reg = 5;
      flat_reg = 300;
      rel_low_reg = 1000;
      rel_high_reg = 2000;
      alt_low_reg = 4000;
      alt_high_reg = 8000;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] d);
      case (idx)
        REG_NUM_COLS: cols_reg = d[NCOL_W-1:0];
        REG_NUM_ROWS: rows_reg = d[ROW_W-1:0];
        REG_RADIUS:   rad_reg = d[RAD_W-1:0];
        REG_FLAT_LIM: flat_reg = d[S_W-1:0];
        REG_REL_LOW:  rel_low_reg = d[REL_W-1:0];
        REG_REL_HIGH: rel_high_reg = d[REL_W-1:0];
        REG_ALT_LOW:  alt_low_reg = d[H_W-1:0];
        REG_ALT_HIGH: alt_high_reg = d[H_W-1:0];
      endcase
      row_pos = 0;
      col_pos = 0;
    endfunction

    function logic [CLS_W-1:0] classify(int unsigned cr, int unsigned cc, int unsigned rad);
      logic [H_W:0]          centre;
      logic [H_W:0]          e;
      logic [S_W:0]          s;
      logic signed [H_W-1:0] hs;
      longint                h;
      longint                v;
      longint                hmin;
      longint                hmax;
      longint                relief;
      longint unsigned       ssum;
      longint unsigned       scount;
      bit                    any;
      centre = height_ring[cr % RING_ROWS][cc];
      if (!centre[H_W]) return CLS_NONE;
      hs = centre[H_W-1:0];
      h = hs;
      ssum = 0;
      scount = 0;
      any = 0;
      hmin = 0;
      hmax = 0;
      for (int unsigned r = cr - rad; r <= cr + rad; r++) begin
        for (int unsigned c = cc - rad; c <= cc + rad; c++) begin
          s = slope_ring[r % RING_ROWS][c];
          e = height_ring[r % RING_ROWS][c];
          if (s[S_W]) begin
            ssum += s[S_W-1:0];
            scount++;
          end
          if (e[H_W]) begin
            hs = e[H_W-1:0];
            v = hs;
            if (!any || v < hmin) hmin = v;
            if (!any || v > hmax) hmax = v;
            any = 1;
          end
        end
      end
      relief = hmax - hmin;
      if (ssum <= longint'(flat_reg) * scount) return CLS_FLAT;
      if (relief <= longint'(rel_low_reg)) return CLS_LOW;
      if (relief <= longint'(rel_high_reg) && h <= longint'(alt_low_reg)) return CLS_HILL;
      if (relief > longint'(rel_high_reg)) begin
        if (h > longint'(alt_low_reg) && h <= longint'(alt_high_reg)) return CLS_MID;
        if (h > longint'(alt_high_reg)) return CLS_HIGH;
      end
      return CLS_NONE;
    endfunction

    function void note_cell(logic [H_W-1:0] hgt, logic hv, logic [S_W-1:0] slp, logic sv);
      int unsigned cols;
      int unsigned rows;
      int unsigned rad;
      int unsigned r;
      int unsigned c;
      landform_t   res;
      cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
      rows = (rows_reg == 0) ? 1 : rows_reg;
      rad = (rad_reg == 0) ? 1 : (rad_reg > MAX_RADIUS) ? MAX_RADIUS : rad_reg;
      if (col_pos >= cols) col_pos = 0;
      if (row_pos >= rows) row_pos = 0;
      r = row_pos;
      c = col_pos;
      height_ring[r % RING_ROWS][c] = {hv, hgt};
      slope_ring[r % RING_ROWS][c] = {sv, slp};
      if (r >= 2 * rad && c >= 2 * rad) begin
        res.row = ROW_W'(r - rad);
        res.col = COL_W'(c - rad);
        res.cls = classify(r - rad, c - rad, rad);
        res.last = (r == rows - 1 && c == cols - 1);
        expected_q.push_back(res);
      end
      if (c + 1 >= cols) begin
        col_pos = 0;
        row_pos = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void report(string field, longint unsigned exp_v, longint unsigned act_v);
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(landform_t act);
      landform_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d col %0d class %0d",
                 $time, act.row, act.col, act.cls);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.row !== act.row) report("center_row", exp_r.row, act.row);
      if (exp_r.col !== act.col) report("center_col", exp_r.col, act.col);
      if (exp_r.cls !== act.cls) report("landform_class", exp_r.cls, act.cls);
      if (exp_r.last !== act.last) report("last", exp_r.last, act.last);
    endfunction
  endclass

  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_A_W-1:0]    cfg_addr;
  logic [CFG_D_W-1:0]    cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [H_W-1:0] in_height;
  logic                  in_height_valid;
  logic [S_W-1:0]        in_slope;
  logic                  in_slope_valid;
  logic                  out_valid;
  logic                  out_ready;
  logic [ROW_W-1:0]      out_center_row;
  logic [COL_W-1:0]      out_center_col;
  logic [CLS_W-1:0]      out_landform_class;
  logic                  out_last;

  landform_scoreboard sb = new();

  // Shared knobs: steady turns off idling on both sides; holdoff_req asks the
  // receiver to stop taking results for a long stretch.
  bit steady = 0;
  bit holdoff_req = 0;

  dem_landform_window_classifier_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_addr           (cfg_addr),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_height          (in_height),
    .in_height_valid    (in_height_valid),
    .in_slope           (in_slope),
    .in_slope_valid     (in_slope_valid),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_center_row     (out_center_row),
    .out_center_col     (out_center_col),
    .out_landform_class (out_landform_class),
    .out_last           (out_last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles in which no channel moves a request. The
  // longest honest quiet spell is the receiver hold-off plus one full
  // radius 7 window sweep, well under the limit.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function bit idle_now();
    return !steady && $urandom_range(0, 99) < 24;
  endfunction

  // Result side: checks every accepted request, then decides readiness for
  // the next cycle, either at random or held low during a requested hold-off.
  initial begin
    int holdoff_left;
    landform_t act;
    holdoff_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        act.row = out_center_row;
        act.col = out_center_col;
        act.cls = out_landform_class;
        act.last = out_last;
        sb.check_result(act);
      end
      if (holdoff_req) begin
        holdoff_left = 400;
        holdoff_req = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_now();
      end
    end
  end

  // Offers one cell and waits for its acceptance. Valid is only lowered in
  // idle cycles, so back-to-back cells keep it high without a glitch.
  task automatic send_cell(logic [H_W-1:0] h, logic hv, logic [S_W-1:0] s, logic sv);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_height <= h;
    in_height_valid <= hv;
    in_slope <= s;
    in_slope_valid <= sv;
    do @(posedge clk); while (!in_ready);
    sb.note_cell(h, hv, s, sv);
  endtask

  // Lowers valid and waits until every queued classification has come back,
  // then lets border cells still in the pipe drain out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all eight registers back to back; valid drops only after the last.
  task automatic configure(int cols, int rows, int rad, int flat,
                           int rlo, int rhi, int alo, int ahi);
    logic [CFG_D_W-1:0] vals [8];
    logic [CFG_A_W-1:0] idx [8];
    idx = '{REG_NUM_COLS, REG_NUM_ROWS, REG_RADIUS, REG_FLAT_LIM,
            REG_REL_LOW, REG_REL_HIGH, REG_ALT_LOW, REG_ALT_HIGH};
    vals = '{cols, rows, rad, flat, rlo, rhi, alo, ahi};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random cells around a base height: the spread sets the relief and the
  // slope ceiling sets how often the flat test passes. Now and then a field
  // jumps to its extreme or a validity flag drops.
  task automatic random_phase(int n, int hbase, int hspread, int smax, bit pause_mid);
    logic [H_W-1:0] h;
    logic [S_W-1:0] s;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 15);
      h = (pick == 0) ? -131072 : (pick == 1) ? 131071 : hbase + $urandom_range(0, hspread);
      pick = $urandom_range(0, 15);
      s = (pick == 0) ? 0 : (pick == 1) ? 9000 : $urandom_range(0, smax);
      send_cell(h, $urandom_range(0, 9) != 0, s, $urandom_range(0, 7) != 0);
    end
    drain();
  endtask

  initial begin
    logic [H_W-1:0] h;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_addr <= REG_NUM_COLS;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_height <= '0;
    in_height_valid <= 1'b0;
    in_slope <= '0;
    in_slope_valid <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x3 frames with radius 1, so each frame is exactly one window.
    // First a window with no valid slope (flat), then a hill whose relief lies
    // between the limits with the centre below the low altitude, then a
    // window holding both height extremes with every slope at 9000.
    configure(3, 3, 1, 100, 100, 200, 0, 1000);
    for (int f = 0; f < 3; f++) begin
      for (int k = 0; k < 9; k++) begin
        case (f)
          0: send_cell(500, 1'b1, S_W'(0), 1'b0);
          1: send_cell((k == 4) ? -10 : -160, 1'b1, 9000, 1'b1);
          default: begin
            h = (k == 0) ? -131072 : (k == 4) ? 131071 : 50;
            send_cell(h, 1'b1, 9000, 1'b1);
          end
        endcase
      end
    end
    drain();

    // Small frames that wrap several times, first with no idling at all.
    steady = 1;
    configure(8, 6, 1, 300, 50, 150, 1000, 1100);
    random_phase(200, 1000, 400, 600, 1'b0);
    steady = 0;

    // Radius 2; the sender pauses halfway until the block has caught up.
    configure(12, 9, 2, 2000, 1000, 3000, 2000, 4000);
    random_phase(250, 1000, 5000, 4500, 1'b1);

    // Radius 3 with the receiver holding off early, so the block backs up
    // and stalls its input while the sender keeps offering cells.
    configure(17, 12, 3, 0, 0, 131071, -131072, 131071);
    holdoff_req = 1;
    random_phase(250, -5000, 3000, 9000, 1'b0);

    // Largest window; limits at the far ends.
    configure(20, 17, 7, 16383, 131071, 0, 131071, -131072);
    random_phase(340, 20000, 90000, 9000, 1'b0);

    // Out of range sizes: zero width acts as one column, so nothing comes out;
    // then zero radius acts as radius one.
    configure(0, 5, 3, 300, 100, 200, 0, 100);
    random_phase(10, 0, 500, 600, 1'b0);
    configure(5, 5, 0, 300, 100, 300, -200, 300);
    random_phase(60, -100, 600, 700, 1'b0);

    // Narrow frame with the tallest row count, so the rows never wrap.
    configure(6, 65535, 1, 500, 200, 800, 100, 600);
    random_phase(360, 0, 1200, 1000, 1'b0);

    drain();
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
